// ----- design/lock_manager_deadlock_detect_core_macros.svh -----
// ----------------------------------------------------------------------------
// Lock manager assertion macros
// Shared assertion forms for the lock manager checker.
// ----------------------------------------------------------------------------
`ifndef LOCK_MANAGER_DEADLOCK_DETECT_CORE_MACROS_SVH
`define LOCK_MANAGER_DEADLOCK_DETECT_CORE_MACROS_SVH

// Check a property outside of reset
`define LMDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property that also holds across reset
`define LMDD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/lmdd_pkg.sv -----
// ----------------------------------------------------------------------------
// Lock manager package
// Sizes, request and status codes, and controller/datapath types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lmdd_pkg;

  localparam int MAX_THREADS = 16;
  localparam int MAX_MUTEXES = 32;
  localparam int ACT_W  = 3;
  localparam int ST_W   = 3;
  localparam int TID_W  = 4;
  localparam int MID_W  = 5;
  localparam int TCNT_W = 5;
  localparam int MCNT_W = 6;
  localparam int ECNT_W = 8;
  localparam int PCNT_W = 5;

  // Request actions
  localparam logic [ACT_W-1:0] ACT_NEW_THREAD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_NEW_MUTEX  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOCK       = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UNLOCK     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_JOIN       = 3'd4;
  localparam logic [ACT_W-1:0] ACT_FINISH     = 3'd5;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_THREAD = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_MUTEX  = 3'd2;
  localparam logic [ST_W-1:0] ST_BUSY      = 3'd3;
  localparam logic [ST_W-1:0] ST_DEADLOCK  = 3'd4;
  localparam logic [ST_W-1:0] ST_NOT_OWNER = 3'd5;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd6;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [TID_W-1:0] thread_id;
    logic [MID_W-1:0] mutex_id;
    logic [TID_W-1:0] target_thread;
  } req_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;
    logic srch_start;
    logic srch_first;
    logic srch_step;
    logic hit_save;
    logic exec;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic srch_stable;
    logic out_free;
  } sts_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_START1 = 7'b0000010,
    S_SRCH1  = 7'b0000100,
    S_EXEC   = 7'b0001000,
    S_START2 = 7'b0010000,
    S_SRCH2  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  function automatic logic [PCNT_W-1:0] popcnt(input logic [MAX_THREADS-1:0] v);
    logic [PCNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_THREADS; i++) n = n + PCNT_W'(v[i]);
    return n;
  endfunction

endpackage

// ----- design/lmdd_if.sv -----
// ----------------------------------------------------------------------------
// Lock manager channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface lmdd_in_if;
  import lmdd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [TID_W-1:0] thread_id;
  logic [MID_W-1:0] mutex_id;
  logic [TID_W-1:0] target_thread;
  modport source (output valid, action, thread_id, mutex_id, target_thread, input ready);
  modport sink   (input valid, action, thread_id, mutex_id, target_thread, output ready);
endinterface

interface lmdd_out_if;
  import lmdd_pkg::*;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [ST_W-1:0]   status;
  logic [MID_W-1:0]  new_id;
  logic              would_deadlock;
  logic              mutex_locked;
  logic [TID_W-1:0]  mutex_owner;
  logic              thread_active;
  logic              deadlock_free;
  logic [TCNT_W-1:0] thread_count;
  logic [MCNT_W-1:0] mutex_count;
  logic [ECNT_W-1:0] edge_count;
  modport source (output valid, ok, status, new_id, would_deadlock, mutex_locked,
                  mutex_owner, thread_active, deadlock_free, thread_count,
                  mutex_count, edge_count, input ready);
  modport sink   (input valid, ok, status, new_id, would_deadlock, mutex_locked,
                  mutex_owner, thread_active, deadlock_free, thread_count,
                  mutex_count, edge_count, output ready);
endinterface

// ----- design/lock_manager_deadlock_detect_core.sv -----
// Flow: a request is captured in IDLE, then the controller runs START1, SRCH1, EXEC,
// START2, SRCH2 and DONE; each search steps the frontier until it is stable.
// Throughput: one request in flight; the next is taken the cycle after the result
// loads into the output register, and a stalled result holds the controller.
// The length of the two searches over wait-for rows sets how far apart requests are.
// Reset (synchronous, active low) empties all tables and drops the result.
// ----------------------------------------------------------------------------
// Lock manager with deadlock detection
// Thread, mutex owner and wait-for tables with cycle refusal on waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lock_manager_deadlock_detect_core (
  input logic       clk,
  input logic       rst_n,
  lmdd_in_if.sink   in_ch,
  lmdd_out_if.source out_ch
);
  import lmdd_pkg::*;

  cmd_t cmd;
  sts_t sts;
  req_t req;
  logic in_ready;

  // Gather request fields
  assign req.action        = in_ch.action;
  assign req.thread_id     = in_ch.thread_id;
  assign req.mutex_id      = in_ch.mutex_id;
  assign req.target_thread = in_ch.target_thread;
  assign in_ch.ready       = in_ready;

  lmdd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lmdd_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_in (req),
    .cmd    (cmd),
    .sts    (sts),
    .out_ch (out_ch)
  );

endmodule

// ----- design/lmdd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Lock manager controller
// Sequences request capture, two reachability searches, update and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lmdd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lmdd_pkg::sts_t sts,
  output lmdd_pkg::cmd_t cmd
);
  import lmdd_pkg::*;

  state_t state_r, state_nxt;

  // Decode state into commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_START1;
        end
      end
      S_START1: begin
        cmd.srch_start = 1'b1;
        cmd.srch_first = 1'b1;
        state_nxt      = S_SRCH1;
      end
      S_SRCH1: begin
        if (sts.srch_stable) begin
          cmd.hit_save = 1'b1;
          state_nxt    = S_EXEC;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_START2;
      end
      S_START2: begin
        cmd.srch_start = 1'b1;
        state_nxt      = S_SRCH2;
      end
      S_SRCH2: begin
        if (sts.srch_stable) state_nxt = S_DONE;
        else cmd.srch_step = 1'b1;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ----- design/lmdd_dpath.sv -----
// ----------------------------------------------------------------------------
// Lock manager datapath
// Thread, owner and wait-for tables, frontier search and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lmdd_dpath (
  input  logic           clk,
  input  logic           rst_n,
  input  lmdd_pkg::req_t req_in,
  input  lmdd_pkg::cmd_t cmd,
  output lmdd_pkg::sts_t sts,
  lmdd_out_if.source     out_ch
);
  import lmdd_pkg::*;

  req_t                   req_r;
  logic [TCNT_W-1:0]      threads_made_r, threads_made_nxt;
  logic [MAX_THREADS-1:0] alive_r, alive_nxt;
  logic [MCNT_W-1:0]      mutexes_made_r, mutexes_made_nxt;
  logic [MAX_MUTEXES-1:0] held_r, held_nxt;
  logic [TID_W-1:0]       owner_r [MAX_MUTEXES];
  logic [TID_W-1:0]       owner_nxt [MAX_MUTEXES];
  logic [MAX_THREADS-1:0] wm_r [MAX_THREADS];
  logic [MAX_THREADS-1:0] wm_nxt [MAX_THREADS];
  logic [TCNT_W-1:0]      thread_cnt_r, thread_cnt_nxt;
  logic [ECNT_W-1:0]      edge_cnt_r, edge_cnt_nxt;
  logic [MAX_THREADS-1:0] frontier_r;
  logic                   hit_r;
  logic                   ok_r, ok_nxt;
  logic [ST_W-1:0]        status_r, status_nxt;
  logic [MID_W-1:0]       new_id_r, new_id_nxt;
  logic                   out_valid_r;

  logic [TID_W-1:0]       tid, tgt, own, srch_node;
  logic [MID_W-1:0]       mid;
  logic                   tok, tgok, mok, cyc, wd, locked;
  logic [MAX_THREADS-1:0] row, col, reach_or, next_front;
  logic [PCNT_W-1:0]      row_pop, col_pop;

  assign tid    = req_r.thread_id;
  assign tgt    = req_r.target_thread;
  assign mid    = req_r.mutex_id;
  assign own    = owner_r[mid];
  assign tok    = alive_r[tid];
  assign tgok   = alive_r[tgt];
  assign mok    = {1'b0, mid} < mutexes_made_r;
  assign locked = mok && held_r[mid];
  assign row    = wm_r[tid];

  // Column of waiters on the acting thread
  always_comb begin
    for (int i = 0; i < MAX_THREADS; i++) col[i] = wm_r[i][tid];
  end
  assign row_pop = popcnt(row);
  assign col_pop = popcnt(col);

  // Expand the frontier by one hop
  always_comb begin
    reach_or = '0;
    for (int i = 0; i < MAX_THREADS; i++) begin
      if (frontier_r[i]) reach_or = reach_or | wm_r[i];
    end
  end
  assign next_front      = frontier_r | reach_or;
  assign sts.srch_stable = (next_front == frontier_r);
  assign sts.out_free    = !out_valid_r || out_ch.ready;

  // First search starts at the join target, otherwise at the mutex owner
  assign srch_node = (cmd.srch_first && req_r.action == ACT_JOIN) ? tgt : own;

  // Waiting on a thread that reaches the waiter closes a cycle
  assign cyc = hit_r || ((req_r.action == ACT_JOIN) ? (tgt == tid) : (own == tid));
  assign wd  = tok && locked && (own == tid || frontier_r[tid]);

  // Apply the request to the tables
  always_comb begin
    threads_made_nxt = threads_made_r;
    alive_nxt        = alive_r;
    mutexes_made_nxt = mutexes_made_r;
    held_nxt         = held_r;
    owner_nxt        = owner_r;
    wm_nxt           = wm_r;
    thread_cnt_nxt   = thread_cnt_r;
    edge_cnt_nxt     = edge_cnt_r;
    ok_nxt           = 1'b0;
    status_nxt       = ST_OK;
    new_id_nxt       = '0;
    if (cmd.exec) begin
      unique case (req_r.action)
        ACT_NEW_THREAD: begin
          if (threads_made_r == TCNT_W'(MAX_THREADS)) begin
            status_nxt = ST_FULL;
          end else begin
            new_id_nxt = MID_W'(threads_made_r);
            alive_nxt[threads_made_r[TID_W-1:0]] = 1'b1;
            threads_made_nxt = threads_made_r + 1'b1;
            thread_cnt_nxt   = thread_cnt_r + 1'b1;
            ok_nxt           = 1'b1;
          end
        end
        ACT_NEW_MUTEX: begin
          if (mutexes_made_r == MCNT_W'(MAX_MUTEXES)) begin
            status_nxt = ST_FULL;
          end else begin
            new_id_nxt = mutexes_made_r[MID_W-1:0];
            held_nxt[mutexes_made_r[MID_W-1:0]]  = 1'b0;
            owner_nxt[mutexes_made_r[MID_W-1:0]] = '0;
            mutexes_made_nxt = mutexes_made_r + 1'b1;
            ok_nxt           = 1'b1;
          end
        end
        ACT_LOCK: begin
          if (!tok) begin
            status_nxt = ST_NO_THREAD;
          end else if (!mok) begin
            status_nxt = ST_NO_MUTEX;
          end else if (!held_r[mid]) begin
            held_nxt[mid]  = 1'b1;
            owner_nxt[mid] = tid;
            wm_nxt[tid]    = '0;
            edge_cnt_nxt   = edge_cnt_r - ECNT_W'(row_pop);
            ok_nxt         = 1'b1;
          end else if (cyc) begin
            wm_nxt[tid]  = '0;
            edge_cnt_nxt = edge_cnt_r - ECNT_W'(row_pop);
            status_nxt   = ST_DEADLOCK;
          end else begin
            wm_nxt[tid][own] = 1'b1;
            edge_cnt_nxt     = edge_cnt_r + ECNT_W'(!row[own]);
            status_nxt       = ST_BUSY;
          end
        end
        ACT_UNLOCK: begin
          if (!tok) begin
            status_nxt = ST_NO_THREAD;
          end else if (!mok) begin
            status_nxt = ST_NO_MUTEX;
          end else if (!held_r[mid] || own != tid) begin
            status_nxt = ST_NOT_OWNER;
          end else begin
            held_nxt[mid]  = 1'b0;
            owner_nxt[mid] = '0;
            wm_nxt[tid]    = '0;
            edge_cnt_nxt   = edge_cnt_r - ECNT_W'(row_pop);
            ok_nxt         = 1'b1;
          end
        end
        ACT_JOIN: begin
          if (!tok || !tgok) begin
            status_nxt = ST_NO_THREAD;
          end else if (cyc) begin
            wm_nxt[tid]  = '0;
            edge_cnt_nxt = edge_cnt_r - ECNT_W'(row_pop);
            status_nxt   = ST_DEADLOCK;
          end else begin
            wm_nxt[tid][tgt] = 1'b1;
            edge_cnt_nxt     = edge_cnt_r + ECNT_W'(!row[tgt]);
            ok_nxt           = 1'b1;
          end
        end
        ACT_FINISH: begin
          if ({1'b0, tid} >= threads_made_r) begin
            status_nxt = ST_NO_THREAD;
          end else begin
            if (tok) thread_cnt_nxt = thread_cnt_r - 1'b1;
            alive_nxt[tid] = 1'b0;
            // Release every mutex the thread holds
            for (int m = 0; m < MAX_MUTEXES; m++) begin
              if (held_r[m] && owner_r[m] == tid) begin
                held_nxt[m]  = 1'b0;
                owner_nxt[m] = '0;
              end
            end
            // Drop edges into and out of the thread
            for (int i = 0; i < MAX_THREADS; i++) wm_nxt[i][tid] = 1'b0;
            wm_nxt[tid]  = '0;
            edge_cnt_nxt = edge_cnt_r - ECNT_W'(row_pop) - ECNT_W'(col_pop)
                           + ECNT_W'(row[tid]);
            ok_nxt       = 1'b1;
          end
        end
        default: ok_nxt = 1'b1;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threads_made_r <= '0;
      alive_r        <= '0;
      mutexes_made_r <= '0;
      held_r         <= '0;
      thread_cnt_r   <= '0;
      edge_cnt_r     <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < MAX_THREADS; i++) wm_r[i] <= '0;
      for (int m = 0; m < MAX_MUTEXES; m++) owner_r[m] <= '0;
    end else begin
      threads_made_r <= threads_made_nxt;
      alive_r        <= alive_nxt;
      mutexes_made_r <= mutexes_made_nxt;
      held_r         <= held_nxt;
      thread_cnt_r   <= thread_cnt_nxt;
      edge_cnt_r     <= edge_cnt_nxt;
      wm_r           <= wm_nxt;
      owner_r        <= owner_nxt;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) req_r <= req_in;
    if (cmd.srch_start) frontier_r <= wm_r[srch_node];
    else if (cmd.srch_step) frontier_r <= next_front;
    if (cmd.hit_save) hit_r <= frontier_r[tid];
    if (cmd.exec) begin
      ok_r     <= ok_nxt;
      status_r <= status_nxt;
      new_id_r <= new_id_nxt;
    end
    if (cmd.out_load) begin
      out_ch.ok             <= ok_r;
      out_ch.status         <= status_r;
      out_ch.new_id         <= new_id_r;
      out_ch.would_deadlock <= wd;
      out_ch.mutex_locked   <= locked;
      out_ch.mutex_owner    <= locked ? own : '0;
      out_ch.thread_active  <= tok;
      out_ch.thread_count   <= thread_cnt_r;
      out_ch.mutex_count    <= mutexes_made_r;
      out_ch.edge_count     <= edge_cnt_r;
    end
  end

  // Refused waits keep the graph acyclic at all times
  assign out_ch.deadlock_free = 1'b1;
  assign out_ch.valid         = out_valid_r;

endmodule

// ----- design/lmdd_checker.sv -----
// ----------------------------------------------------------------------------
// Lock manager port checker
// Checks handshake and result invariants seen on the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lock_manager_deadlock_detect_core_macros.svh"
module lmdd_port_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_ok,
  input logic [lmdd_pkg::ST_W-1:0]  out_status,
  input logic                       out_deadlock_free,
  input logic [lmdd_pkg::TCNT_W-1:0] out_thread_count
);
  import lmdd_pkg::*;

  // Hold a stalled result
  `LMDD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_status), "result dropped while stalled")
  // One transaction in flight
  `LMDD_ASSERT(a_one_req, in_valid && in_ready |=> !in_ready, "second request taken while busy")
  // Success carries the ok status
  `LMDD_ASSERT(a_ok_status, out_valid && out_ok |-> out_status == ST_OK, "ok result with error status")
  // Graph stays acyclic and count in range
  `LMDD_ASSERT(a_graph, out_valid |-> out_deadlock_free && out_thread_count <= TCNT_W'(MAX_THREADS), "bad graph state")
  // Reset drops the result
  `LMDD_ASSERT_RST(a_rst, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind lock_manager_deadlock_detect_core lmdd_port_checker u_lmdd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_ok            (out_ch.ok),
  .out_status        (out_ch.status),
  .out_deadlock_free (out_ch.deadlock_free),
  .out_thread_count  (out_ch.thread_count)
);
